// ===== sv/pixel_cluster_eta_bin_unit_macros.svh =====
// Assertion macros for the pixel cluster eta bin unit checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef PIXEL_CLUSTER_ETA_BIN_UNIT_MACROS_SVH
`define PIXEL_CLUSTER_ETA_BIN_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PCEB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pceb check failed");

// Next-cycle implication, checked out of reset.
`define PCEB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pceb check failed");

`endif

// ===== sv/pceb_pkg.sv =====
// Package of the pixel cluster eta bin unit: word types, constants and state codes.
// Used by every module of the block; depends on nothing.
package pceb_pkg;

  localparam int unsigned MAX_DIGITS_DEF = 64;
  localparam int unsigned MAX_EDGES_DEF  = 6;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned DIV_STEPS      = 17;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CHARGE_W   = 16;
  localparam int unsigned ETA_W      = 17;
  localparam int unsigned INDEX_W    = 6;
  localparam int unsigned BIN_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_EDGE_0 = 3'd1;

  localparam logic [ETA_W-1:0] ETA_HALF = 17'd32768;

  typedef struct packed {
    logic [9:0]  cell_row;
    logic [9:0]  cluster_row_start;
    logic [6:0]  cluster_height;
    logic        angle_u_negative;
    logic        angle_v_negative;
    logic [15:0] digit_charge;
    logic        last_digit;
  } in_word_t;

  typedef struct packed {
    logic [16:0] eta_fraction;
    logic [2:0]  eta_bin;
    logic [5:0]  head_index;
    logic [5:0]  tail_index;
    logic        zero_charge_sum;
  } out_word_t;

  typedef struct packed {
    logic [CHARGE_W-1:0] head_charge;
    logic [CHARGE_W-1:0] tail_charge;
    logic [INDEX_W-1:0]  head_index;
    logic [INDEX_W-1:0]  tail_index;
    logic                same_digit;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

endpackage

// ===== sv/pixel_cluster_eta_bin_unit.sv =====
// Usage: digits of one cluster enter on the in channel (in_valid_i / in_ready_o,
// payload in_word_i), v-sorted, with last_digit set on the final digit of the cluster.
// One result word per cluster leaves on the out channel (out_valid_o / out_ready_i).
// The front takes one digit per cycle and keeps up a full digit rate as long as
// its two-entry job queue has room; in_ready_o drops only while that queue is full.
// The back handles one cluster at a time: it takes a job from the queue, runs the
// bit-serial divider (skipped when head and tail are the same digit or their
// charges sum to zero), then does the bin search into the output register.
// It takes no new cluster until the last has reached the output register, while
// digits still enter at one per cycle as long as the queue has room.
// A stalled receiver holds the result in the output register while the back
// finishes the next division, and the queue then absorbs two more clusters.
// Reset clears the edge count, the bin edges and all cluster tracking state.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i. The user
// must write them only while idle; the block itself does not enforce this.
// Depends on pceb_pkg, pceb_front, pceb_queue and pceb_back.
module pixel_cluster_eta_bin_unit #(
  parameter int unsigned MAX_DIGITS = pceb_pkg::MAX_DIGITS_DEF,
  parameter int unsigned MAX_EDGES  = pceb_pkg::MAX_EDGES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pceb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pceb_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  pceb_pkg::in_word_t              in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output pceb_pkg::out_word_t             out_word_o
);

  logic           accept;
  logic           push;
  logic           pop;
  logic           q_empty;
  logic           q_full;
  pceb_pkg::job_t push_job;
  pceb_pkg::job_t pop_job;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && !q_full;

  pceb_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .word_i   (in_word_i),
    .push_o   (push),
    .job_o    (push_job)
  );

  pceb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_job),
    .pop_i       (pop),
    .pop_word_o  (pop_job),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  pceb_back #(
    .MAX_EDGES (MAX_EDGES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_empty_i   (q_empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== sv/pceb_front.sv =====
// Front part of the pixel cluster eta bin unit: tracks the four candidate digits
// of a cluster and emits one head/tail job per cluster. Depends on pceb_pkg.
module pceb_front #(
  parameter int unsigned MAX_DIGITS = pceb_pkg::MAX_DIGITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  pceb_pkg::in_word_t word_i,
  output logic              push_o,
  output pceb_pkg::job_t    job_o
);

  localparam int unsigned PW = $clog2(MAX_DIGITS);

  logic [PW-1:0]               count_q, count_d;
  logic [pceb_pkg::CHARGE_W-1:0] first_q, first_d;
  logic [pceb_pkg::CHARGE_W-1:0] prev_q, prev_d;
  logic [PW-1:0]               cpos_q [4];
  logic [PW-1:0]               cpos_d [4];
  logic [pceb_pkg::CHARGE_W-1:0] cchg_q [4];
  logic [pceb_pkg::CHARGE_W-1:0] cchg_d [4];
  logic [3:0]                  cset_q, cset_d;

  logic [PW-1:0]               fpos [4];
  logic [pceb_pkg::CHARGE_W-1:0] fchg [4];
  logic signed [11:0]          off;
  logic signed [11:0]          tgt_hi;
  logic signed [11:0]          tgt;
  logic [PW-1:0]               n_prev;
  logic [1:0]                  tail_sel;
  logic [1:0]                  head_sel;
  logic [PW+5:0]               head_ext;
  logic [PW+5:0]               tail_ext;

  always_comb begin
    off    = $signed({2'b00, word_i.cell_row}) - $signed({2'b00, word_i.cluster_row_start});
    tgt_hi = $signed({5'b00000, word_i.cluster_height}) - 12'sd1;
    n_prev = (count_q == '0) ? '0 : count_q - PW'(1);
    first_d = (count_q == '0) ? word_i.digit_charge : first_q;
    prev_d  = word_i.digit_charge;
    count_d = (count_q != PW'(MAX_DIGITS - 1)) ? count_q + PW'(1) : count_q;
    for (int k = 0; k < 4; k++) begin
      tgt       = (k < 2) ? 12'sd0 : tgt_hi;
      cpos_d[k] = cpos_q[k];
      cchg_d[k] = cchg_q[k];
      cset_d[k] = cset_q[k];
      if (!cset_q[k]) begin
        if ((k % 2) == 0) begin
          if (off == tgt) begin
            cset_d[k] = 1'b1;
            cpos_d[k] = count_q;
            cchg_d[k] = word_i.digit_charge;
          end
        end else if (tgt < off) begin
          cset_d[k] = 1'b1;
          cpos_d[k] = n_prev;
          cchg_d[k] = (count_q == '0) ? word_i.digit_charge : prev_q;
        end
      end
      if (cset_d[k]) begin
        fpos[k] = cpos_d[k];
        fchg[k] = cchg_d[k];
      end else if ((k % 2) == 0) begin
        fpos[k] = '0;
        fchg[k] = first_d;
      end else begin
        fpos[k] = count_q;
        fchg[k] = word_i.digit_charge;
      end
    end
  end

  // The tail candidate code is the two angle signs; the head is its complement.
  always_comb begin
    tail_sel = {word_i.angle_v_negative, word_i.angle_u_negative};
    head_sel = ~tail_sel;
    head_ext = {6'd0, fpos[head_sel]};
    tail_ext = {6'd0, fpos[tail_sel]};
    job_o.head_charge = fchg[head_sel];
    job_o.tail_charge = fchg[tail_sel];
    job_o.head_index  = head_ext[5:0];
    job_o.tail_index  = tail_ext[5:0];
    job_o.same_digit  = (fpos[head_sel] == fpos[tail_sel]);
    push_o = accept_i && word_i.last_digit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      first_q <= '0;
      prev_q  <= '0;
      cset_q  <= '0;
      for (int k = 0; k < 4; k++) begin
        cpos_q[k] <= '0;
        cchg_q[k] <= '0;
      end
    end else if (accept_i) begin
      if (word_i.last_digit) begin
        count_q <= '0;
        first_q <= '0;
        prev_q  <= '0;
        cset_q  <= '0;
        for (int k = 0; k < 4; k++) begin
          cpos_q[k] <= '0;
          cchg_q[k] <= '0;
        end
      end else begin
        count_q <= count_d;
        first_q <= first_d;
        prev_q  <= prev_d;
        cset_q  <= cset_d;
        for (int k = 0; k < 4; k++) begin
          cpos_q[k] <= cpos_d[k];
          cchg_q[k] <= cchg_d[k];
        end
      end
    end
  end

endmodule

// ===== sv/pceb_queue.sv =====
// Short job queue between the front and back parts of the eta bin unit.
// Depends on pceb_pkg for the job word and the queue depth.
module pceb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pceb_pkg::job_t push_word_i,
  input  logic           pop_i,
  output pceb_pkg::job_t pop_word_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int unsigned DEPTH = pceb_pkg::QUEUE_DEPTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  pceb_pkg::job_t slot_q [DEPTH];
  logic [AW-1:0]  wptr_q, wptr_d;
  logic [AW-1:0]  rptr_q, rptr_d;
  logic [CW-1:0]  fill_q, fill_d;
  logic           do_push;
  logic           do_pop;

  always_comb begin
    empty_o    = (fill_q == '0);
    full_o     = (fill_q == CW'(DEPTH));
    do_push    = push_i && !full_o;
    do_pop     = pop_i && !empty_o;
    pop_word_o = slot_q[rptr_q];
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    fill_d = fill_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_word_i;
    end
  end

endmodule

// ===== sv/pceb_back.sv =====
// Back part of the eta bin unit: bit-serial eta division, bin search over the
// configured edges and the output register. Depends on pceb_pkg.
module pceb_back #(
  parameter int unsigned MAX_EDGES = pceb_pkg::MAX_EDGES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pceb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pceb_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               q_empty_i,
  input  pceb_pkg::job_t                     job_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output pceb_pkg::out_word_t                out_word_o
);

  localparam int unsigned SW = $clog2(pceb_pkg::DIV_STEPS);

  pceb_pkg::back_state_e state_q, state_d;

  logic [2:0]                     edge_count_q;
  logic [pceb_pkg::ETA_W-1:0]     edge_q [MAX_EDGES];

  logic [17:0]                    rem_q;
  logic [17:0]                    den_q;
  logic [pceb_pkg::ETA_W-1:0]     div_q;
  logic [SW-1:0]                  step_q;
  logic                           flag_q;
  logic [pceb_pkg::INDEX_W-1:0]   head_q;
  logic [pceb_pkg::INDEX_W-1:0]   tail_q;

  logic                           out_valid_q;
  pceb_pkg::out_word_t            out_q;

  logic [16:0]                    sum;
  logic [18:0]                    trial;
  logic                           ge;
  logic [17:0]                    rem_d;
  logic [pceb_pkg::ETA_W-1:0]     div_d;
  logic                           last_step;
  logic                           load_out;
  logic [2:0]                     used;
  logic [pceb_pkg::BIN_W-1:0]     bin;

  always_comb begin
    sum       = {1'b0, job_i.head_charge} + {1'b0, job_i.tail_charge};
    trial     = {rem_q, div_q[pceb_pkg::ETA_W-1]};
    ge        = (trial >= {1'b0, den_q});
    rem_d     = ge ? 18'(trial - {1'b0, den_q}) : trial[17:0];
    div_d     = {div_q[pceb_pkg::ETA_W-2:0], ge};
    last_step = (step_q == SW'(pceb_pkg::DIV_STEPS - 1));
  end

  always_comb begin
    used = (edge_count_q > 3'(MAX_EDGES)) ? 3'(MAX_EDGES) : edge_count_q;
    bin  = '0;
    for (int i = 0; i < MAX_EDGES; i++) begin
      if ((3'(i) < used) && (div_q >= edge_q[i])) begin
        bin = 3'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pceb_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          if (job_i.same_digit || (sum == '0)) begin
            state_d = pceb_pkg::BK_DONE;
          end else begin
            state_d = pceb_pkg::BK_DIV;
          end
        end
      end
      pceb_pkg::BK_DIV: begin
        if (last_step) begin
          state_d = pceb_pkg::BK_DONE;
        end
      end
      pceb_pkg::BK_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = pceb_pkg::BK_IDLE;
        end
      end
      default: state_d = pceb_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      pceb_pkg::BK_IDLE: pop_o    = !q_empty_i;
      pceb_pkg::BK_DONE: load_out = !out_valid_q || out_ready_i;
      default: begin
        pop_o    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pceb_pkg::BK_IDLE;
      out_valid_q  <= 1'b0;
      edge_count_q <= '0;
      for (int e = 0; e < MAX_EDGES; e++) begin
        edge_q[e] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i && (cfg_idx_i == pceb_pkg::CFG_EDGE_COUNT)) begin
        edge_count_q <= cfg_wdata_i[2:0];
      end
      for (int e = 0; e < MAX_EDGES; e++) begin
        if (cfg_we_i && (cfg_idx_i == pceb_pkg::CFG_BIN_EDGE_0 + 3'(e))) begin
          edge_q[e] <= cfg_wdata_i;
        end
      end
    end
  end

  // The numerator is tail * 2^17 + sum: its upper part starts the remainder and
  // the sum shifts in below it, so seventeen steps give the quotient.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      head_q <= job_i.head_index;
      tail_q <= job_i.tail_index;
      rem_q  <= {2'b00, job_i.tail_charge};
      den_q  <= {sum, 1'b0};
      step_q <= '0;
      if (job_i.same_digit) begin
        div_q  <= pceb_pkg::ETA_HALF;
        flag_q <= 1'b0;
      end else if (sum == '0) begin
        div_q  <= pceb_pkg::ETA_HALF;
        flag_q <= 1'b1;
      end else begin
        div_q  <= sum;
        flag_q <= 1'b0;
      end
    end else if (state_q == pceb_pkg::BK_DIV) begin
      rem_q  <= rem_d;
      div_q  <= div_d;
      step_q <= step_q + SW'(1);
    end
    if (load_out) begin
      out_q.eta_fraction    <= div_q;
      out_q.eta_bin         <= bin;
      out_q.head_index      <= head_q;
      out_q.tail_index      <= tail_q;
      out_q.zero_charge_sum <= flag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== sv/pceb_checker.sv =====
// Port-level checker of the pixel cluster eta bin unit, bound to the top level.
// Depends on pceb_pkg and pixel_cluster_eta_bin_unit_macros.svh.
`include "pixel_cluster_eta_bin_unit_macros.svh"

module pceb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input pceb_pkg::out_word_t out_word_i
);

  `PCEB_ASSERT_NEXT(a_out_word_held, out_valid_i && !out_ready_i, $stable(out_word_i))
  `PCEB_ASSERT_NOW(a_eta_range, out_valid_i, out_word_i.eta_fraction <= 17'd65536)
  `PCEB_ASSERT_NOW(a_zero_sum_half, out_valid_i && out_word_i.zero_charge_sum, out_word_i.eta_fraction == pceb_pkg::ETA_HALF)
  `PCEB_ASSERT_NOW(a_bin_range, out_valid_i, out_word_i.eta_bin <= 3'd5)

endmodule

bind pixel_cluster_eta_bin_unit pceb_checker u_pceb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_i  (out_word_o)
);

// ===== bench/pixel_cluster_eta_bin_unit_test.sv =====
// Self-checking testbench of pixel_cluster_eta_bin_unit: streams cluster digits, predicts eta,
// bin and head/tail positions per cluster, and compares each result word as it leaves.
// Depends on pceb_pkg and the pixel_cluster_eta_bin_unit RTL.
module pixel_cluster_eta_bin_unit_test;
  import pceb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  typedef enum int {
    SLOT_FIRST_LO,
    SLOT_LAST_LO,
    SLOT_FIRST_HI,
    SLOT_LAST_HI
  } slot_e;

  typedef struct {
    in_word_t word;
    bit       hold;
  } pending_digit_t;

  logic clk_i;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  in_word_t in_word = '0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;

  pending_digit_t digit_backlog[$];
  out_word_t cluster_results_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned digits_queued = 0;
  int unsigned clusters_seen = 0;
  int unsigned zero_sum_seen = 0;
  int unsigned same_digit_seen = 0;

  logic [2:0]  floor_count;
  logic [16:0] bin_floor[6];
  logic [6:0]  seen_digits;
  logic [15:0] first_q;
  logic [15:0] prev_q;
  logic [6:0]  cand_pos[4];
  logic [15:0] cand_q[4];
  bit          cand_done[4];

  pixel_cluster_eta_bin_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void clear_cluster();
    seen_digits = '0;
    first_q = '0;
    prev_q = '0;
    for (int k = 0; k < 4; k++) begin
      cand_pos[k] = '0;
      cand_q[k] = '0;
      cand_done[k] = 1'b0;
    end
  endfunction

  task automatic absorb_digit(input in_word_t w);
    int off;
    int hi_off;
    int tgt;
    int used;
    slot_e head;
    slot_e tail;
    logic [6:0] n;
    logic [16:0] eta;
    logic flag;
    logic [2:0] bin;
    longint unsigned sum;
    longint unsigned num;
    out_word_t r;
    off = int'(w.cell_row) - int'(w.cluster_row_start);
    hi_off = int'(w.cluster_height) - 1;
    n = seen_digits;
    if (n == 0) first_q = w.digit_charge;
    for (int k = 0; k < 4; k++) begin
      tgt = (k < 2) ? 0 : hi_off;
      if (!cand_done[k]) begin
        if (k % 2 == 0) begin
          if (off == tgt) begin
            cand_done[k] = 1'b1;
            cand_pos[k] = n;
            cand_q[k] = w.digit_charge;
          end
        end else if (tgt < off) begin
          cand_done[k] = 1'b1;
          cand_pos[k] = (n == 0) ? 7'd0 : n - 7'd1;
          cand_q[k] = (n == 0) ? w.digit_charge : prev_q;
        end
      end
    end
    prev_q = w.digit_charge;
    if (seen_digits < MAX_DIGITS_DEF - 1) seen_digits = seen_digits + 7'd1;
    if (w.last_digit) begin
      for (int k = 0; k < 4; k++) begin
        if (!cand_done[k]) begin
          if (k % 2 == 0) begin
            cand_pos[k] = '0;
            cand_q[k] = first_q;
          end else begin
            cand_pos[k] = n;
            cand_q[k] = w.digit_charge;
          end
        end
      end
      case ({w.angle_v_negative, w.angle_u_negative})
        2'b00: begin head = SLOT_LAST_HI; tail = SLOT_FIRST_LO; end
        2'b01: begin head = SLOT_FIRST_HI; tail = SLOT_LAST_LO; end
        2'b10: begin head = SLOT_LAST_LO; tail = SLOT_FIRST_HI; end
        default: begin head = SLOT_FIRST_LO; tail = SLOT_LAST_HI; end
      endcase
      flag = 1'b0;
      if (cand_pos[head] == cand_pos[tail]) begin
        eta = ETA_HALF;
        same_digit_seen++;
      end else begin
        sum = longint'(cand_q[head]) + longint'(cand_q[tail]);
        if (sum == 0) begin
          eta = ETA_HALF;
          flag = 1'b1;
          zero_sum_seen++;
        end else begin
          num = (longint'(cand_q[tail]) << 17) + sum;
          eta = 17'(num / (2 * sum));
        end
      end
      used = (floor_count > MAX_EDGES_DEF) ? MAX_EDGES_DEF : floor_count;
      bin = '0;
      for (int i = used; i > 0; i--) begin
        if (eta >= bin_floor[i-1]) begin
          bin = 3'(i - 1);
          break;
        end
      end
      r.eta_fraction = eta;
      r.eta_bin = bin;
      r.head_index = cand_pos[head][5:0];
      r.tail_index = cand_pos[tail][5:0];
      r.zero_charge_sum = flag;
      cluster_results_q.push_back(r);
      clusters_seen++;
      clear_cluster();
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_n) begin : monitor
    out_word_t want;
    int slot;
    if (!rst_n) begin
      floor_count = '0;
      for (int i = 0; i < 6; i++) bin_floor[i] = '0;
      clear_cluster();
    end else begin
      if (cfg_we) begin
        slot = int'(cfg_idx) - int'(CFG_BIN_EDGE_0);
        if (cfg_idx == CFG_EDGE_COUNT) floor_count = cfg_wdata[2:0];
        else if (slot >= 0 && slot < 6) bin_floor[slot] = cfg_wdata;
      end
      if (in_valid && in_ready) absorb_digit(in_word);
      if (out_valid && out_ready) begin
        if (cluster_results_q.size() == 0) begin
          $display("%0t: result word %h with no cluster pending", $time, out_word);
          errors++;
        end else begin
          want = cluster_results_q.pop_front();
          check_field("eta_fraction", want.eta_fraction, out_word.eta_fraction);
          check_field("eta_bin", want.eta_bin, out_word.eta_bin);
          check_field("head_index", want.head_index, out_word.head_index);
          check_field("tail_index", want.tail_index, out_word.tail_index);
          check_field("zero_charge_sum", want.zero_charge_sum, out_word.zero_charge_sum);
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_word <= '0;
    end else if (!in_valid || in_ready) begin
      if (digit_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(digit_backlog[0].hold && (in_valid || cluster_results_q.size() != 0))) begin
        in_valid <= 1'b1;
        in_word <= digit_backlog[0].word;
        void'(digit_backlog.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("[pixel_cluster_eta_bin_unit] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input int idx, input int val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_IDX_W'(idx);
    cfg_wdata <= CFG_DATA_W'(val);
  endtask

  task automatic program_bins(input int count, input int mode);
    int floor_val;
    write_reg(CFG_EDGE_COUNT, count);
    floor_val = 0;
    for (int i = 0; i < 6; i++) begin
      case (mode)
        0: begin
          floor_val = floor_val + $urandom_range(13000);
          if (floor_val > 65536) floor_val = 65536;
        end
        1: floor_val = $urandom_range(65536);
        2: floor_val = 65536;
        default: floor_val = 0;
      endcase
      write_reg(CFG_BIN_EDGE_0 + i, floor_val);
    end
    if (mode == 1) write_reg(CFG_SPARE_IDX, $urandom_range(131071));
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_digit(input int row, input int start, input int hgt, input bit u,
                             input bit v, input int q, input bit last, input bit hold = 1'b0);
    pending_digit_t p;
    p.word.cell_row = row[9:0];
    p.word.cluster_row_start = start[9:0];
    p.word.cluster_height = hgt[6:0];
    p.word.angle_u_negative = u;
    p.word.angle_v_negative = v;
    p.word.digit_charge = q[15:0];
    p.word.last_digit = last;
    p.hold = hold;
    digit_backlog.push_back(p);
    digits_queued++;
  endtask

  function automatic int rand_charge();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 0;
    if (pick < 15) return 16'hFFFF;
    if (pick < 25) return $urandom_range(15);
    return $urandom_range(16'hFFFF);
  endfunction

  task automatic queue_cluster(input bit hold);
    int kind;
    int pick;
    int start;
    int hgt;
    int cnt;
    int reps;
    int span;
    bit u;
    bit v;
    int rows[$];
    kind = $urandom_range(99);
    u = $urandom_range(1);
    v = $urandom_range(1);
    start = $urandom_range(1023);
    rows = {};
    if (kind < 74) begin
      pick = $urandom_range(99);
      if (pick < 75) hgt = $urandom_range(1, 5);
      else if (pick < 90) hgt = $urandom_range(6, 16);
      else if (pick < 96) hgt = $urandom_range(17, 64);
      else if (pick < 99) hgt = $urandom_range(65, 127);
      else hgt = 0;
      if ($urandom_range(99) < 15) rows.push_back(start - 1);
      span = (hgt > 70) ? 70 : hgt;
      for (int r = 0; r < span; r++) begin
        reps = $urandom_range(2);
        if ((r == 0 || r == hgt - 1) && reps == 0 && $urandom_range(99) < 85) reps = 1;
        for (int j = 0; j < reps; j++) rows.push_back(start + r);
      end
      if ($urandom_range(99) < 15) rows.push_back(start + hgt);
      if (rows.size() == 0) rows.push_back(start);
      foreach (rows[i])
        queue_digit(rows[i], start, hgt, u, v, rand_charge(), i == rows.size() - 1,
                    hold && i == 0);
    end else if (kind < 77) begin
      hgt = $urandom_range(1, 3);
      cnt = $urandom_range(64, 75);
      for (int j = 0; j < cnt; j++)
        queue_digit(start + (j * hgt) / cnt, start, hgt, u, v, rand_charge(), j == cnt - 1,
                    hold && j == 0);
    end else begin
      cnt = $urandom_range(1, 5);
      pick = $urandom_range(1);
      for (int j = 0; j < cnt; j++)
        queue_digit($urandom_range(1023), $urandom_range(1023), $urandom_range(127),
                    $urandom_range(1), $urandom_range(1), $urandom_range(16'hFFFF),
                    (j == cnt - 1) || (pick == 1 && $urandom_range(1) == 1), hold && j == 0);
    end
  endtask

  task automatic queue_random(input int unsigned amount);
    int unsigned goal;
    int unsigned made;
    goal = digits_queued + amount;
    made = 0;
    while (digits_queued < goal) begin
      queue_cluster(made == 8);
      made++;
    end
  endtask

  task automatic drain();
    while (digit_backlog.size() != 0 || in_valid) @(posedge clk_i);
    while (cluster_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 21;
    recv_idle_pct = 65;
    write_reg(CFG_EDGE_COUNT, 6);
    write_reg(CFG_BIN_EDGE_0 + 0, 0);
    write_reg(CFG_BIN_EDGE_0 + 1, 8192);
    write_reg(CFG_BIN_EDGE_0 + 2, 24576);
    write_reg(CFG_BIN_EDGE_0 + 3, 32768);
    write_reg(CFG_BIN_EDGE_0 + 4, 49152);
    write_reg(CFG_BIN_EDGE_0 + 5, 65536);
    @(posedge clk_i);
    cfg_we <= 1'b0;

    queue_digit(0, 0, 1, 0, 0, 16'hFFFF, 1);
    queue_digit(5, 5, 2, 0, 0, 0, 0);
    queue_digit(6, 5, 2, 0, 0, 0, 1);
    queue_digit(1022, 1022, 2, 0, 0, 0, 0);
    queue_digit(1023, 1022, 2, 0, 0, 16'hFFFF, 1);
    queue_digit(1022, 1022, 2, 1, 1, 0, 0);
    queue_digit(1023, 1022, 2, 1, 1, 16'hFFFF, 1);
    queue_digit(100, 100, 3, 1, 0, 300, 0);
    queue_digit(100, 100, 3, 1, 0, 200, 0);
    queue_digit(101, 100, 3, 1, 0, 50, 0);
    queue_digit(102, 100, 3, 1, 0, 900, 1);
    queue_digit(100, 100, 3, 0, 1, 7, 0);
    queue_digit(101, 100, 3, 0, 1, 4000, 0);
    queue_digit(102, 100, 3, 0, 1, 123, 0);
    queue_digit(102, 100, 3, 0, 1, 60000, 1);
    queue_digit(9, 10, 0, 0, 0, 1, 0);
    queue_digit(10, 10, 0, 0, 0, 2, 0);
    queue_digit(11, 10, 0, 0, 0, 3, 1);
    queue_digit(1023, 0, 127, 1, 1, 12345, 1);
    queue_digit(201, 200, 3, 0, 0, 500, 0);
    queue_digit(202, 200, 3, 0, 0, 700, 0);
    queue_digit(202, 200, 3, 0, 0, 900, 1);
    queue_digit(3, 1000, 64, 1, 0, 16'h8000, 1);
    drain();

    program_bins(7, 0);
    queue_random(300);
    drain();

    send_idle_pct = 65;
    recv_idle_pct = 21;
    program_bins(3, 1);
    queue_random(300);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_bins(6, 2);
    queue_random(160);
    drain();

    program_bins(0, 0);
    queue_random(160);
    drain();

    if (cluster_results_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, cluster_results_q.size());
      errors++;
    end
    $display("Streamed %0d digits forming %0d clusters under five bin-edge setups;",
             digits_queued, clusters_seen);
    $display("%0d clusters had a zero charge sum and %0d a shared head/tail digit.",
             zero_sum_seen, same_digit_seen);
    if (errors == 0) begin
      $display("[pixel_cluster_eta_bin_unit] OK");
    end else begin
      $display("[pixel_cluster_eta_bin_unit] ERROR");
    end
    $finish;
  end

endmodule
